// File: hdl/tci_pkg.sv
// ----------------------------------------------------------------------------
// tci_pkg
// types, widths and register codes shared by the color interpolator modules
// ----------------------------------------------------------------------------
package tci_pkg;

    localparam int COORD_BITS     = 12;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;

    localparam int GAIN_W   = 32;
    localparam int OFFSET_W = 48;
    localparam int COLOR_W  = 16;
    localparam int NUM_CH   = 4;

    // doubled pixel centre, signed view
    localparam int X2_W   = COORD_BITS + 2;
    localparam int PROD_W = GAIN_W + X2_W;
    localparam int Q32_W  = PROD_W + 4;
    localparam int BARY_W = Q32_W - 16;
    localparam int W0_W   = BARY_W + 1;

    localparam int BPROD_W = W0_W + COLOR_W + 1;
    localparam int BSUM_W  = BPROD_W + 2;
    localparam int CH_W    = 26;
    localparam int PM_W    = 2 * CH_W;

    localparam logic [CFG_INDEX_BITS-1:0] REG_U_GAINS    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_V_GAINS    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_U_OFFSET   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_V_OFFSET   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLOR_ZERO = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLOR_ONE  = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLOR_TWO  = 3'd6;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic                  last_in;
    } tci_in_t;

    typedef struct packed {
        logic [7:0] alpha_out;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       last_out;
    } tci_out_t;

    typedef struct packed {
        logic valid;
        logic last;
    } tci_ctl_t;

    typedef struct packed {
        logic [63:0]         u_gains;
        logic [63:0]         v_gains;
        logic [OFFSET_W-1:0] u_offset;
        logic [OFFSET_W-1:0] v_offset;
        logic [63:0]         color_zero;
        logic [63:0]         color_one;
        logic [63:0]         color_two;
    } tci_cfg_t;

    typedef logic signed [BARY_W-1:0] tci_bary_t;
    typedef logic signed [W0_W-1:0]   tci_w0_t;
    typedef logic signed [CH_W-1:0]   tci_ch_t;

endpackage

// File: hdl/tci_cfg_regs.sv
// ----------------------------------------------------------------------------
// tci_cfg_regs
// configuration register file, one write transfer per cycle
// ----------------------------------------------------------------------------
module tci_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tci_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [tci_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output tci_pkg::tci_cfg_t                   cfg
);
    import tci_pkg::*;

    tci_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_U_GAINS:    cfg_reg.u_gains    <= cfg_data;
                REG_V_GAINS:    cfg_reg.v_gains    <= cfg_data;
                REG_U_OFFSET:   cfg_reg.u_offset   <= cfg_data[OFFSET_W-1:0];
                REG_V_OFFSET:   cfg_reg.v_offset   <= cfg_data[OFFSET_W-1:0];
                REG_COLOR_ZERO: cfg_reg.color_zero <= cfg_data;
                REG_COLOR_ONE:  cfg_reg.color_one  <= cfg_data;
                REG_COLOR_TWO:  cfg_reg.color_two  <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// File: hdl/tci_bary_map.sv
// ----------------------------------------------------------------------------
// tci_bary_map
// three stages: gain products, offset add and rounding to Q.16, vertex zero weight
// ----------------------------------------------------------------------------
module tci_bary_map (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              ce,
    input  tci_pkg::tci_ctl_t                 in_ctl,
    input  logic [tci_pkg::COORD_BITS-1:0]    pixel_x,
    input  logic [tci_pkg::COORD_BITS-1:0]    pixel_y,
    input  tci_pkg::tci_cfg_t                 cfg,
    output tci_pkg::tci_ctl_t                 out_ctl,
    output tci_pkg::tci_bary_t                u,
    output tci_pkg::tci_bary_t                v,
    output tci_pkg::tci_w0_t                  w0
);
    import tci_pkg::*;

    localparam logic signed [Q32_W-1:0] ROUND_Q16 = Q32_W'(32'h8000);
    localparam logic signed [W0_W-1:0]  ONE_Q16   = W0_W'(32'h1_0000);

    tci_ctl_t ctl_a_reg, ctl_b_reg, ctl_c_reg;

    logic signed [X2_W-1:0]   x2, y2;
    logic signed [PROD_W-1:0] ux_next, uy_next, vx_next, vy_next;
    logic signed [PROD_W-1:0] ux_reg, uy_reg, vx_reg, vy_reg;
    logic signed [Q32_W-1:0]  u_q32, v_q32;
    tci_bary_t                u_next, v_next, u_b_reg, v_b_reg, u_c_reg, v_c_reg;
    tci_w0_t                  w0_next, w0_reg;

    // stage a: gains times doubled pixel centre
    always_comb begin
        x2      = $signed({1'b0, pixel_x, 1'b1});
        y2      = $signed({1'b0, pixel_y, 1'b1});
        ux_next = PROD_W'($signed(cfg.u_gains[63:32])) * PROD_W'(x2);
        uy_next = PROD_W'($signed(cfg.u_gains[31:0])) * PROD_W'(y2);
        vx_next = PROD_W'($signed(cfg.v_gains[63:32])) * PROD_W'(x2);
        vy_next = PROD_W'($signed(cfg.v_gains[31:0])) * PROD_W'(y2);
    end

    // stage b: Q.32 sum, round half up to Q.16
    always_comb begin
        u_q32  = (Q32_W'(ux_reg) <<< 2) + (Q32_W'(uy_reg) <<< 2)
               + Q32_W'($signed(cfg.u_offset)) + ROUND_Q16;
        v_q32  = (Q32_W'(vx_reg) <<< 2) + (Q32_W'(vy_reg) <<< 2)
               + Q32_W'($signed(cfg.v_offset)) + ROUND_Q16;
        u_next = u_q32[Q32_W-1:16];
        v_next = v_q32[Q32_W-1:16];
    end

    // stage c: weight of vertex zero
    assign w0_next = ONE_Q16 - W0_W'(u_b_reg) - W0_W'(v_b_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
        end else if (ce) begin
            ctl_a_reg <= in_ctl;
            ctl_b_reg <= ctl_a_reg;
            ctl_c_reg <= ctl_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ux_reg  <= ux_next;
            uy_reg  <= uy_next;
            vx_reg  <= vx_next;
            vy_reg  <= vy_next;
            u_b_reg <= u_next;
            v_b_reg <= v_next;
            u_c_reg <= u_b_reg;
            v_c_reg <= v_b_reg;
            w0_reg  <= w0_next;
        end
    end

    assign out_ctl = ctl_c_reg;
    assign u       = u_c_reg;
    assign v       = v_c_reg;
    assign w0      = w0_reg;

endmodule

// File: hdl/tci_blend.sv
// ----------------------------------------------------------------------------
// tci_blend
// two stages: weighted vertex channels, then sum, round to Q.16 and clamp
// ----------------------------------------------------------------------------
module tci_blend (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   ce,
    input  tci_pkg::tci_ctl_t      in_ctl,
    input  tci_pkg::tci_bary_t     u,
    input  tci_pkg::tci_bary_t     v,
    input  tci_pkg::tci_w0_t       w0,
    input  tci_pkg::tci_cfg_t      cfg,
    output tci_pkg::tci_ctl_t      out_ctl,
    output tci_pkg::tci_ch_t       ch [tci_pkg::NUM_CH]
);
    import tci_pkg::*;

    localparam int Q16_W = BSUM_W - 15;
    localparam logic signed [BSUM_W-1:0] ROUND_Q15 = BSUM_W'(32'h4000);
    localparam logic signed [Q16_W-1:0]  CH_MAX    = Q16_W'(32'h100_0000);
    localparam logic signed [Q16_W-1:0]  CH_MIN    = -CH_MAX;

    tci_ctl_t ctl_d_reg, ctl_e_reg;

    logic signed [BPROD_W-1:0] p0_next [NUM_CH];
    logic signed [BPROD_W-1:0] p1_next [NUM_CH];
    logic signed [BPROD_W-1:0] p2_next [NUM_CH];
    logic signed [BPROD_W-1:0] p0_reg  [NUM_CH];
    logic signed [BPROD_W-1:0] p1_reg  [NUM_CH];
    logic signed [BPROD_W-1:0] p2_reg  [NUM_CH];
    logic signed [BSUM_W-1:0]  sum     [NUM_CH];
    logic signed [Q16_W-1:0]   q16     [NUM_CH];
    tci_ch_t                   ch_next [NUM_CH];
    tci_ch_t                   ch_reg  [NUM_CH];

    // stage d: alpha from the top lane down to blue
    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            p0_next[k] = BPROD_W'($signed({1'b0,
                             cfg.color_zero[COLOR_W*(NUM_CH-1-k) +: COLOR_W]}))
                       * BPROD_W'(w0);
            p1_next[k] = BPROD_W'($signed({1'b0,
                             cfg.color_one[COLOR_W*(NUM_CH-1-k) +: COLOR_W]}))
                       * BPROD_W'(u);
            p2_next[k] = BPROD_W'($signed({1'b0,
                             cfg.color_two[COLOR_W*(NUM_CH-1-k) +: COLOR_W]}))
                       * BPROD_W'(v);
        end
    end

    // stage e
    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            sum[k] = BSUM_W'(p0_reg[k]) + BSUM_W'(p1_reg[k]) + BSUM_W'(p2_reg[k])
                   + ROUND_Q15;
            q16[k] = sum[k][BSUM_W-1:15];
            if (q16[k] > CH_MAX) begin
                ch_next[k] = CH_MAX[CH_W-1:0];
            end else if (q16[k] < CH_MIN) begin
                ch_next[k] = CH_MIN[CH_W-1:0];
            end else begin
                ch_next[k] = q16[k][CH_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_d_reg <= '0;
            ctl_e_reg <= '0;
        end else if (ce) begin
            ctl_d_reg <= in_ctl;
            ctl_e_reg <= ctl_d_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < NUM_CH; k++) begin
                p0_reg[k] <= p0_next[k];
                p1_reg[k] <= p1_next[k];
                p2_reg[k] <= p2_next[k];
                ch_reg[k] <= ch_next[k];
            end
        end
    end

    assign out_ctl = ctl_e_reg;
    assign ch      = ch_reg;

endmodule

// File: hdl/tci_premul.sv
// ----------------------------------------------------------------------------
// tci_premul
// two stages: alpha products, then scale by 255, round, saturate into the
// output register
// ----------------------------------------------------------------------------
module tci_premul (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  ce,
    input  tci_pkg::tci_ctl_t     in_ctl,
    input  tci_pkg::tci_ch_t      ch [tci_pkg::NUM_CH],
    output tci_pkg::tci_ctl_t     out_ctl,
    output tci_pkg::tci_out_t     out_data
);
    import tci_pkg::*;

    localparam int SAT_W = 28;
    localparam int AS_W  = CH_W + 8;
    localparam int SC_W  = PM_W + 8;
    localparam int NUM_COLOR = NUM_CH - 1;

    localparam logic signed [AS_W-1:0] ROUND_A = AS_W'(32'h8000);
    localparam logic signed [SC_W-1:0] ROUND_C = SC_W'(64'h8000_0000);

    function automatic logic [7:0] sat8(input logic signed [SAT_W-1:0] val);
        logic [7:0] res;
        if (val < 0) begin
            res = 8'd0;
        end else if (val > SAT_W'(255)) begin
            res = 8'd255;
        end else begin
            res = val[7:0];
        end
        return res;
    endfunction

    tci_ctl_t ctl_f_reg, ctl_g_reg;

    logic signed [AS_W-1:0]      a_scaled;
    logic signed [AS_W-17:0]     a_round;
    logic [7:0]                  a8_next, a8_reg;
    logic signed [PM_W-1:0]      pm_next [NUM_COLOR];
    logic signed [PM_W-1:0]      pm_reg  [NUM_COLOR];
    logic signed [SC_W-1:0]      c_scaled [NUM_COLOR];
    logic [7:0]                  c8 [NUM_COLOR];
    tci_out_t                    out_next, out_reg;

    // stage f
    always_comb begin
        a_scaled = (AS_W'(ch[0]) <<< 8) - AS_W'(ch[0]) + ROUND_A;
        a_round  = a_scaled[AS_W-1:16];
        a8_next  = sat8(SAT_W'(a_round));
        for (int k = 0; k < NUM_COLOR; k++) begin
            pm_next[k] = PM_W'(ch[0]) * PM_W'(ch[k+1]);
        end
    end

    // stage g
    always_comb begin
        for (int k = 0; k < NUM_COLOR; k++) begin
            c_scaled[k] = (SC_W'(pm_reg[k]) <<< 8) - SC_W'(pm_reg[k]) + ROUND_C;
            c8[k]       = sat8($signed(c_scaled[k][SC_W-1:32]));
        end
        out_next.alpha_out = a8_reg;
        out_next.red_out   = c8[0];
        out_next.green_out = c8[1];
        out_next.blue_out  = c8[2];
        out_next.last_out  = ctl_f_reg.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_f_reg <= '0;
            ctl_g_reg <= '0;
        end else if (ce) begin
            ctl_f_reg <= in_ctl;
            ctl_g_reg <= ctl_f_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            a8_reg  <= a8_next;
            out_reg <= out_next;
            for (int k = 0; k < NUM_COLOR; k++) begin
                pm_reg[k] <= pm_next[k];
            end
        end
    end

    assign out_ctl  = ctl_g_reg;
    assign out_data = out_reg;

endmodule

// File: hdl/triangle_color_interpolator.sv
// ----------------------------------------------------------------------------
// triangle_color_interpolator
// seven register stages from the input transfer to the result on m_valid and m_data;
// one pixel per cycle while m_ready is high or the output register is empty
// all seven stages, output register included, stall as one when m_ready is low
// reset clears the valid bits and sets every configuration register to zero
// ----------------------------------------------------------------------------
module triangle_color_interpolator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tci_pkg::tci_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tci_pkg::tci_out_t                   m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tci_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [tci_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import tci_pkg::*;

    tci_cfg_t  cfg;
    tci_ctl_t  in_ctl, map_ctl, blend_ctl, out_ctl;
    tci_bary_t u, v;
    tci_w0_t   w0;
    tci_ch_t   ch [NUM_CH];
    logic      ce;

    // pipeline advances when the output register is empty or being drained
    assign ce      = !out_ctl.valid || m_ready;
    assign s_ready = ce;
    assign m_valid = out_ctl.valid;

    assign in_ctl.valid = s_valid;
    assign in_ctl.last  = s_data.last_in;

    tci_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tci_bary_map u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .in_ctl  (in_ctl),
        .pixel_x (s_data.pixel_x),
        .pixel_y (s_data.pixel_y),
        .cfg     (cfg),
        .out_ctl (map_ctl),
        .u       (u),
        .v       (v),
        .w0      (w0)
    );

    tci_blend u_blend (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .in_ctl  (map_ctl),
        .u       (u),
        .v       (v),
        .w0      (w0),
        .cfg     (cfg),
        .out_ctl (blend_ctl),
        .ch      (ch)
    );

    tci_premul u_premul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_ctl   (blend_ctl),
        .ch       (ch),
        .out_ctl  (out_ctl),
        .out_data (m_data)
    );

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the triangle color interpolator: an in-bench model
// of the barycentric blend and premultiply predicts every output pixel; directed
// corner cases and extreme register values run first, then random triangles and
// random register values run under random input gaps and output stalls
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import tci_pkg::*;

    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;
    localparam longint HALF_Q16  = 64'sd32768;
    localparam longint HALF_Q15  = 64'sd16384;
    localparam longint HALF_Q32  = 64'sd2147483648;
    localparam longint CH_LIMIT  = 64'sd16777216;
    localparam longint ONE_Q16   = 64'sd65536;
    localparam int     RANDOM_PHASES = 10;
    localparam int     PHASE_PIXELS  = 110;

    logic     aclk      = 1'b0;
    logic     aresetn   = 1'b0;
    logic     s_valid   = 1'b0;
    logic     s_ready;
    tci_in_t  s_data    = '0;
    logic     m_valid;
    logic     m_ready   = 1'b0;
    tci_out_t m_data;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    // shadow copy of the shading registers
    logic [63:0]         mdl_u_gains    = '0;
    logic [63:0]         mdl_v_gains    = '0;
    logic [OFFSET_W-1:0] mdl_u_offset   = '0;
    logic [OFFSET_W-1:0] mdl_v_offset   = '0;
    logic [63:0]         mdl_color_zero = '0;
    logic [63:0]         mdl_color_one  = '0;
    logic [63:0]         mdl_color_two  = '0;

    tci_out_t expected_colors[$];

    int fail_count      = 0;
    int pixels_sent     = 0;
    int results_checked = 0;
    int cfg_writes      = 0;
    int settings_loaded = 0;
    int burst_left      = 0;
    bit gaps_on         = 1'b0;
    bit stall_on        = 1'b0;
    int hold_left       = 0;

    triangle_color_interpolator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // color model
    // ------------------------------------------------------------------
    function automatic logic [7:0] clip_byte(longint v);
        if (v < 0) return 8'h00;
        if (v > 255) return 8'hFF;
        return 8'(v);
    endfunction

    function automatic longint map_bary(logic [63:0] gains, logic [OFFSET_W-1:0] offset,
                                        longint x2, longint y2);
        longint gx, gy, q32;
        gx  = longint'($signed(gains[63:32]));
        gy  = longint'($signed(gains[31:0]));
        q32 = gx * x2 * 4 + gy * y2 * 4 + longint'($signed(offset));
        return (q32 + HALF_Q16) >>> 16;
    endfunction

    function automatic longint blend_channel(int sh, longint w0, longint u, longint v);
        longint c0, c1, c2, q16;
        c0  = longint'(mdl_color_zero[sh +: COLOR_W]);
        c1  = longint'(mdl_color_one[sh +: COLOR_W]);
        c2  = longint'(mdl_color_two[sh +: COLOR_W]);
        q16 = (c0 * w0 + c1 * u + c2 * v + HALF_Q15) >>> 15;
        if (q16 > CH_LIMIT) return CH_LIMIT;
        if (q16 < -CH_LIMIT) return -CH_LIMIT;
        return q16;
    endfunction

    function automatic logic [7:0] premultiply(longint a, longint c);
        return clip_byte((a * c * 255 + HALF_Q32) >>> 32);
    endfunction

    function automatic tci_out_t shade_pixel(tci_in_t px);
        tci_out_t res;
        longint x2, y2, u, v, w0, a;
        x2 = longint'(px.pixel_x) * 2 + 1;
        y2 = longint'(px.pixel_y) * 2 + 1;
        u  = map_bary(mdl_u_gains, mdl_u_offset, x2, y2);
        v  = map_bary(mdl_v_gains, mdl_v_offset, x2, y2);
        w0 = ONE_Q16 - u - v;
        a  = blend_channel(48, w0, u, v);
        res.alpha_out = clip_byte((a * 255 + HALF_Q16) >>> 16);
        res.red_out   = premultiply(a, blend_channel(32, w0, u, v));
        res.green_out = premultiply(a, blend_channel(16, w0, u, v));
        res.blue_out  = premultiply(a, blend_channel(0, w0, u, v));
        res.last_out  = px.last_in;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // transfer monitor and result checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        tci_out_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_U_GAINS:    mdl_u_gains    = cfg_data;
                    REG_V_GAINS:    mdl_v_gains    = cfg_data;
                    REG_U_OFFSET:   mdl_u_offset   = cfg_data[OFFSET_W-1:0];
                    REG_V_OFFSET:   mdl_v_offset   = cfg_data[OFFSET_W-1:0];
                    REG_COLOR_ZERO: mdl_color_zero = cfg_data;
                    REG_COLOR_ONE:  mdl_color_one  = cfg_data;
                    REG_COLOR_TWO:  mdl_color_two  = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_colors.push_back(shade_pixel(s_data));
            end
            if (m_valid && m_ready) begin
                if (expected_colors.size() == 0) begin
                    $error("result transfer with no pixel pending");
                    fail_count++;
                end else begin
                    want = expected_colors.pop_front();
                    results_checked++;
                    if (m_data.alpha_out !== want.alpha_out) begin
                        $error("alpha_out expected %0d actual %0d", want.alpha_out,
                               m_data.alpha_out);
                        fail_count++;
                    end
                    if (m_data.red_out !== want.red_out) begin
                        $error("red_out expected %0d actual %0d", want.red_out, m_data.red_out);
                        fail_count++;
                    end
                    if (m_data.green_out !== want.green_out) begin
                        $error("green_out expected %0d actual %0d", want.green_out,
                               m_data.green_out);
                        fail_count++;
                    end
                    if (m_data.blue_out !== want.blue_out) begin
                        $error("blue_out expected %0d actual %0d", want.blue_out,
                               m_data.blue_out);
                        fail_count++;
                    end
                    if (m_data.last_out !== want.last_out) begin
                        $error("last_out expected %0b actual %0b", want.last_out,
                               m_data.last_out);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result side stall pattern
    // ------------------------------------------------------------------
    initial begin
        int  run_left;
        bit  ready_phase;
        run_left    = 0;
        ready_phase = 1'b1;
        forever begin
            @(posedge aclk);
            if (hold_left != 0) begin
                m_ready   <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!stall_on) begin
                m_ready <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    ready_phase = !ready_phase;
                    run_left    = ready_phase ? $urandom_range(1, 15) : $urandom_range(1, 6);
                end
                run_left--;
                m_ready <= ready_phase;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cfg_writes++;
        @(posedge aclk);
    endtask

    task automatic load_shading(input tci_cfg_t c, input logic [15:0] junk);
        cfg_write(REG_U_GAINS, c.u_gains);
        cfg_write(REG_V_GAINS, c.v_gains);
        cfg_write(REG_U_OFFSET, {junk, c.u_offset});
        cfg_write(REG_V_OFFSET, {~junk, c.v_offset});
        cfg_write(REG_COLOR_ZERO, c.color_zero);
        cfg_write(REG_COLOR_ONE, c.color_one);
        cfg_write(REG_COLOR_TWO, c.color_two);
        settings_loaded++;
    endtask

    task automatic send_pixel(input tci_in_t px);
        s_valid <= 1'b1;
        s_data  <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pixels_sent++;
    endtask

    task automatic send_paced(input tci_in_t px);
        int n;
        if (gaps_on && burst_left == 0) begin
            n = $urandom_range(0, 6);
            if (n != 0) begin
                s_valid <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        send_pixel(px);
        if (burst_left != 0) burst_left--;
    endtask

    task automatic send_xy(input int x, input int y, input bit last);
        tci_in_t px;
        px.pixel_x = 12'(x);
        px.pixel_y = 12'(y);
        px.last_in = last;
        send_pixel(px);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_colors.size() != 0) @(posedge aclk);
    endtask

    // one span of adjacent pixels ending with last set, or a stray pixel
    task automatic send_span();
        tci_in_t px;
        int len;
        logic [COORD_BITS-1:0] x0;
        if ($urandom_range(0, 6) == 0) begin
            px.pixel_x = 12'($urandom);
            px.pixel_y = 12'($urandom);
            px.last_in = 1'($urandom);
            send_paced(px);
        end else begin
            x0  = 12'($urandom);
            len = $urandom_range(1, 24);
            px.pixel_y = 12'($urandom);
            for (int i = 0; i < len; i++) begin
                px.pixel_x = x0 + 12'(i);
                px.last_in = (i == len - 1);
                send_paced(px);
            end
        end
    endtask

    function automatic logic [31:0] gain_draw();
        return 32'(int'($urandom_range(0, 524288)) - 262144);
    endfunction

    function automatic logic [63:0] color_draw();
        if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
        return {16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
                16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768))};
    endfunction

    function automatic tci_cfg_t random_triangle();
        tci_cfg_t c;
        c.u_gains    = {gain_draw(), gain_draw()};
        c.v_gains    = {gain_draw(), gain_draw()};
        c.u_offset   = 48'(longint'(int'($urandom)) * 4);
        c.v_offset   = 48'(longint'(int'($urandom)) * 4);
        c.color_zero = color_draw();
        c.color_one  = color_draw();
        c.color_two  = color_draw();
        return c;
    endfunction

    function automatic tci_cfg_t random_registers();
        tci_cfg_t c;
        c.u_gains    = {$urandom, $urandom};
        c.v_gains    = {$urandom, $urandom};
        c.u_offset   = 48'({$urandom, $urandom});
        c.v_offset   = 48'({$urandom, $urandom});
        c.color_zero = {$urandom, $urandom};
        c.color_one  = {$urandom, $urandom};
        c.color_two  = {$urandom, $urandom};
        return c;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_state();
        send_xy(0, 0, 1'b0);
        send_xy(4095, 4095, 1'b1);
        wait_drained();
    endtask

    task automatic test_unit_triangle();
        tci_cfg_t c;
        c.u_gains    = 64'h00020000_00000000;
        c.v_gains    = 64'h00000000_00020000;
        c.u_offset   = '0;
        c.v_offset   = '0;
        c.color_zero = 64'h8000_8000_0000_0000;
        c.color_one  = 64'h8000_0000_8000_0000;
        c.color_two  = 64'h8000_0000_0000_8000;
        load_shading(c, 16'h0000);
        send_xy(0, 0, 1'b0);
        send_xy(4095, 0, 1'b0);
        send_xy(0, 4095, 1'b1);
        send_xy(2048, 1024, 1'b0);
        send_xy(4095, 4095, 1'b1);
        wait_drained();
    endtask

    task automatic test_extreme_registers();
        tci_cfg_t c;
        c.u_gains    = 64'h7FFFFFFF_80000000;
        c.v_gains    = 64'h80000000_7FFFFFFF;
        c.u_offset   = 48'h7FFF_FFFF_FFFF;
        c.v_offset   = 48'h8000_0000_0000;
        c.color_zero = 64'hFFFF_FFFF_FFFF_FFFF;
        c.color_one  = 64'h0000_0000_0000_0000;
        c.color_two  = 64'hFFFF_FFFF_FFFF_FFFF;
        load_shading(c, 16'hFFFF);
        send_xy(0, 0, 1'b1);
        send_xy(4095, 4095, 1'b0);
        send_xy(4095, 0, 1'b1);
        send_xy(0, 4095, 1'b0);
        wait_drained();
        // vertex zero weight far below zero: negative clamp on every channel
        c.u_gains    = '0;
        c.v_gains    = '0;
        c.u_offset   = 48'h03E8_0000_0000;
        c.v_offset   = '0;
        c.color_one  = '0;
        c.color_two  = '0;
        load_shading(c, 16'h5A5A);
        send_xy(17, 300, 1'b0);
        send_xy(4095, 1, 1'b1);
        wait_drained();
        // vertex zero weight far above one: positive clamp
        c.u_offset = 48'hFC18_0000_0000;
        load_shading(c, 16'hA5A5);
        send_xy(1, 4095, 1'b0);
        send_xy(2730, 1365, 1'b1);
        wait_drained();
    endtask

    task automatic test_unused_index();
        cfg_write(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_xy(100, 200, 1'b0);
        send_xy(3000, 50, 1'b1);
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        tci_in_t px;
        load_shading(random_triangle(), 16'($urandom));
        gaps_on   = 1'b0;
        stall_on <= 1'b0;
        hold_left <= 200;
        for (int i = 0; i < 60; i++) begin
            px.pixel_x = 12'($urandom);
            px.pixel_y = 12'($urandom);
            px.last_in = 1'($urandom);
            send_pixel(px);
        end
        wait_drained();
    endtask

    task automatic test_random_shading();
        int start;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph % 4 == 3) load_shading(random_registers(), 16'($urandom));
            else load_shading(random_triangle(), 16'($urandom));
            gaps_on    = (ph % 5 != 0) && ($urandom_range(0, 3) != 0);
            stall_on  <= (ph % 5 != 0) && ($urandom_range(0, 3) != 0);
            burst_left = 0;
            start      = pixels_sent;
            while (pixels_sent - start < PHASE_PIXELS) send_span();
            wait_drained();
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_unit_triangle();
        test_extreme_registers();
        test_unused_index();
        test_output_backpressure();
        test_random_shading();
        stall_on <= 1'b0;
        wait_drained();
        repeat (20) @(posedge aclk);
        if (expected_colors.size() != 0) begin
            $error("%0d pixels never produced a result", expected_colors.size());
            fail_count++;
        end
        $display("shaded %0d pixels and compared %0d results", pixels_sent, results_checked);
        $display("used %0d register writes across %0d shading setups, with stalls and gaps",
                 cfg_writes, settings_loaded);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/tci_pkg.sv
hdl/tci_cfg_regs.sv
hdl/tci_bary_map.sv
hdl/tci_blend.sv
hdl/tci_premul.sv
hdl/triangle_color_interpolator.sv
tb/sv/tb_top.sv
